// ===== hdl/ffed_pkg.sv =====
// Shared types, constants and helper functions of the flux field endpoint detector.
`default_nettype none

package ffed_pkg;

    localparam int FLUX_W     = 16;
    localparam int THR_W      = 15;
    localparam int WIDTH_W    = 12;
    localparam int COL_W      = 11;
    localparam int MAX_WIDTH  = 2048;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam int SEC_W      = 3;
    localparam int PIX_W      = SEC_W + 1;
    localparam int LINE_W     = PIX_W + 1;
    localparam int PROD_W     = 2 * FLUX_W + 1;
    localparam int SQ_W       = 2 * FLUX_W - 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH         = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

    // direction sectors, named after the neighbor they point at
    localparam logic [SEC_W-1:0] SEC_D  = 3'd0;
    localparam logic [SEC_W-1:0] SEC_DR = 3'd1;
    localparam logic [SEC_W-1:0] SEC_R  = 3'd2;
    localparam logic [SEC_W-1:0] SEC_UR = 3'd3;
    localparam logic [SEC_W-1:0] SEC_U  = 3'd4;
    localparam logic [SEC_W-1:0] SEC_UL = 3'd5;
    localparam logic [SEC_W-1:0] SEC_L  = 3'd6;
    localparam logic [SEC_W-1:0] SEC_DL = 3'd7;

    typedef struct packed {
        logic                     op;
        logic signed [FLUX_W-1:0] flux_down;
        logic signed [FLUX_W-1:0] flux_right;
    } in_item_t;

    typedef struct packed {
        logic             is_ending;
        logic [COL_W-1:0] pixel_column;
        logic             row_done;
        logic             frame_done;
    } out_item_t;

    // position and row flags of a pixel as it moves down the pipeline
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             last;
        logic             flush;
        logic             row_ge1;
        logic             row_ge2;
    } pos_t;

    function automatic logic [SEC_W-1:0] sector_of(
        input logic narrow_down,
        input logic narrow_right,
        input logic neg_down,
        input logic neg_right
    );
        logic [SEC_W-1:0] s;
        if (narrow_down)
            s = neg_down ? SEC_U : SEC_D;
        else if (narrow_right)
            s = neg_right ? SEC_L : SEC_R;
        else if (!neg_down)
            s = neg_right ? SEC_DL : SEC_DR;
        else
            s = neg_right ? SEC_UL : SEC_UR;
        return s;
    endfunction

    // window masks: bit 0 left, bit 1 center, bit 2 right
    function automatic logic is_end(
        input logic [PIX_W-1:0] ctr,
        input logic [2:0]       top,
        input logic [2:0]       mid,
        input logic [2:0]       bot,
        input logic             topv,
        input logic             botv,
        input logic             leftv,
        input logic             rightv
    );
        logic nb_mask;
        logic nb_ok;
        case (ctr[SEC_W-1:0])
            SEC_D:
            begin
                nb_mask = bot[1];
                nb_ok   = botv;
            end
            SEC_DR:
            begin
                nb_mask = bot[2];
                nb_ok   = botv && rightv;
            end
            SEC_R:
            begin
                nb_mask = mid[2];
                nb_ok   = rightv;
            end
            SEC_UR:
            begin
                nb_mask = top[2];
                nb_ok   = topv && rightv;
            end
            SEC_U:
            begin
                nb_mask = top[1];
                nb_ok   = topv;
            end
            SEC_UL:
            begin
                nb_mask = top[0];
                nb_ok   = topv && leftv;
            end
            SEC_L:
            begin
                nb_mask = mid[0];
                nb_ok   = leftv;
            end
            SEC_DL:
            begin
                nb_mask = bot[0];
                nb_ok   = botv && leftv;
            end
            default:
            begin
                nb_mask = 1'b1;
                nb_ok   = 1'b0;
            end
        endcase
        return ctr[SEC_W] && nb_ok && !nb_mask;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ffed_if.sv =====
// Valid/ready stream interfaces for pixel input and endpoint results.
`default_nettype none

interface ffed_in_if;
    logic               valid;
    logic               ready;
    ffed_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ffed_out_if;
    logic                valid;
    logic                ready;
    ffed_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/flux_field_endpoint_detector.sv =====
// Top level of the flux field endpoint detector.
// Takes a raster of two-component flux vectors, one pixel per transfer, and flags
// foreground pixels whose pointed-at neighbor is background. Results lag the input
// by one row: pixel (r, c) is reported while row r+1 streams in, so every frame must
// be followed by one flush row (op = 1 on its first pixel). The block accepts one
// pixel per clock unless the result output stalls; the last pixel of each row after
// the first yields two results through the single output register and holds the input
// for the second. An input passes three classify stages (magnitude, products, compares),
// the line-store read and the output register. The line store is one 5-bit x 2048 RAM
// with one read and one write per pixel and is not cleared. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
`default_nettype none

module flux_field_endpoint_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    ffed_in_if.sink                          pixel,
    ffed_out_if.source                       result,
    input  logic                             cfg_we,
    input  logic [ffed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffed_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [ffed_pkg::THR_W-1:0]   thr_reg;
    logic [ffed_pkg::WIDTH_W-1:0] width_reg;

    logic                         px_valid;
    logic                         px_ready;
    logic [ffed_pkg::PIX_W-1:0]   px_code;
    ffed_pkg::pos_t               px_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= '0;
            width_reg <= ffed_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ffed_pkg::REG_MAGNITUDE_THRESHOLD: thr_reg   <= cfg_data[ffed_pkg::THR_W-1:0];
                ffed_pkg::REG_IMAGE_WIDTH:         width_reg <= cfg_data[ffed_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    ffed_classify u_classify (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .threshold   (thr_reg),
        .image_width (width_reg),
        .px_valid    (px_valid),
        .px_ready    (px_ready),
        .px_code     (px_code),
        .px_pos      (px_pos)
    );

    ffed_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .px_valid (px_valid),
        .px_ready (px_ready),
        .px_code  (px_code),
        .px_pos   (px_pos),
        .result   (result)
    );

endmodule

`default_nettype wire

// ===== hdl/ffed_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ffed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/ffed_classify.sv =====
// Pixel position tracking and three-stage foreground / direction classification.
`default_nettype none

module ffed_classify (
    input  logic                          clk,
    input  logic                          rst_n,
    ffed_in_if.sink                       pixel,
    input  logic [ffed_pkg::THR_W-1:0]    threshold,
    input  logic [ffed_pkg::WIDTH_W-1:0]  image_width,
    output logic                          px_valid,
    input  logic                          px_ready,
    output logic [ffed_pkg::PIX_W-1:0]    px_code,
    output ffed_pkg::pos_t                px_pos
);

    localparam logic [1:0] ROW_SAT = 2'd2;

    function automatic logic [ffed_pkg::FLUX_W-1:0] magnitude(
        input logic [ffed_pkg::FLUX_W-1:0] x
    );
        return x[ffed_pkg::FLUX_W-1] ? (~x + 1'b1) : x;
    endfunction

    // position counters; row count saturates at 2 (only >=1 and >=2 matter)
    logic [ffed_pkg::COL_W-1:0]   col_reg;
    logic [1:0]                   row_reg;
    logic                         flush_reg;

    logic [ffed_pkg::COL_W-1:0]   last_col;
    logic                         at_start;
    logic                         flush_now;
    logic                         drop;
    logic                         last;
    logic                         accept;
    ffed_pkg::pos_t               pos_in;

    logic                         s1_v_reg;
    logic [ffed_pkg::FLUX_W-1:0]  s1_a_reg;
    logic [ffed_pkg::FLUX_W-1:0]  s1_b_reg;
    logic                         s1_nd_reg;
    logic                         s1_nr_reg;
    ffed_pkg::pos_t               s1_pos_reg;

    logic                         s2_v_reg;
    logic [ffed_pkg::SQ_W-1:0]    s2_aa_reg;
    logic [ffed_pkg::SQ_W-1:0]    s2_bb_reg;
    logic [ffed_pkg::SQ_W-1:0]    s2_tt_reg;
    logic [ffed_pkg::SQ_W-1:0]    s2_pa_reg;
    logic [ffed_pkg::SQ_W-1:0]    s2_pb_reg;
    logic                         s2_gta_reg;
    logic                         s2_gtb_reg;
    logic                         s2_nd_reg;
    logic                         s2_nr_reg;
    ffed_pkg::pos_t               s2_pos_reg;

    logic                         s3_v_reg;
    logic [ffed_pkg::PIX_W-1:0]   s3_code_reg;
    ffed_pkg::pos_t               s3_pos_reg;

    logic                         s1_adv;
    logic                         s2_adv;
    logic                         s3_adv;

    logic [ffed_pkg::FLUX_W:0]    a17;
    logic [ffed_pkg::FLUX_W:0]    b17;
    logic [ffed_pkg::FLUX_W:0]    a2;
    logic [ffed_pkg::FLUX_W:0]    b2;
    logic [ffed_pkg::FLUX_W:0]    da;
    logic [ffed_pkg::FLUX_W:0]    db;
    logic                         gta;
    logic                         gtb;
    logic [ffed_pkg::PROD_W-1:0]  aa_full;
    logic [ffed_pkg::PROD_W-1:0]  bb_full;
    logic [ffed_pkg::PROD_W-1:0]  tt_full;
    logic [ffed_pkg::PROD_W-1:0]  pa_full;
    logic [ffed_pkg::PROD_W-1:0]  pb_full;

    logic [ffed_pkg::SQ_W:0]      mag_sum;
    logic                         fg;
    logic                         narrow_down;
    logic                         narrow_right;
    logic [ffed_pkg::PIX_W-1:0]   code_next;

    always_comb
    begin
        if (image_width < ffed_pkg::WIDTH_MIN)
            last_col = ffed_pkg::COL_W'(1);
        else if (image_width > ffed_pkg::WIDTH_MAX)
            last_col = ffed_pkg::COL_W'(ffed_pkg::MAX_WIDTH - 1);
        else
            last_col = ffed_pkg::COL_W'(image_width - 1'b1);
    end

    assign at_start  = (col_reg == '0);
    assign flush_now = at_start ? pixel.data.op : flush_reg;
    assign drop      = at_start && pixel.data.op && (row_reg == '0);
    assign last      = (col_reg >= last_col);
    assign accept    = pixel.valid && pixel.ready;

    assign pos_in.col     = col_reg;
    assign pos_in.last    = last;
    assign pos_in.flush   = flush_now;
    assign pos_in.row_ge1 = (row_reg != '0);
    assign pos_in.row_ge2 = (row_reg == ROW_SAT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            flush_reg <= 1'b0;
        end
        else if (accept && !drop)
        begin
            if (last)
            begin
                col_reg   <= '0;
                flush_reg <= 1'b0;
                if (flush_now)
                    row_reg <= '0;
                else if (row_reg != ROW_SAT)
                    row_reg <= row_reg + 1'b1;
            end
            else
            begin
                col_reg   <= col_reg + 1'b1;
                flush_reg <= flush_now;
            end
        end
    end

    // stall chain
    assign s3_adv      = !s3_v_reg || px_ready;
    assign s2_adv      = !s2_v_reg || s3_adv;
    assign s1_adv      = !s1_v_reg || s2_adv;
    assign pixel.ready = s1_adv;

    // stage 2 products
    assign a17     = {1'b0, s1_a_reg};
    assign b17     = {1'b0, s1_b_reg};
    assign a2      = {s1_a_reg, 1'b0};
    assign b2      = {s1_b_reg, 1'b0};
    assign gta     = a17 > b2;
    assign gtb     = b17 > a2;
    assign da      = a17 - b2;
    assign db      = b17 - a2;
    assign aa_full = ffed_pkg::PROD_W'(s1_a_reg) * ffed_pkg::PROD_W'(s1_a_reg);
    assign bb_full = ffed_pkg::PROD_W'(s1_b_reg) * ffed_pkg::PROD_W'(s1_b_reg);
    assign tt_full = ffed_pkg::PROD_W'(threshold) * ffed_pkg::PROD_W'(threshold);
    assign pa_full = ffed_pkg::PROD_W'(s1_a_reg) * ffed_pkg::PROD_W'(da);
    assign pb_full = ffed_pkg::PROD_W'(s1_b_reg) * ffed_pkg::PROD_W'(db);

    // stage 3 compares: b < tan(22.5)*a  <=>  b^2 < a*(a-2b)
    assign mag_sum      = {1'b0, s2_aa_reg} + {1'b0, s2_bb_reg};
    assign fg           = mag_sum > {1'b0, s2_tt_reg};
    assign narrow_down  = s2_gta_reg && (s2_bb_reg < s2_pa_reg);
    assign narrow_right = s2_gtb_reg && (s2_aa_reg < s2_pb_reg);

    always_comb
    begin
        if (s2_pos_reg.flush || !fg)
            code_next = '0;
        else
            code_next = {1'b1, ffed_pkg::sector_of(narrow_down, narrow_right,
                                                   s2_nd_reg, s2_nr_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_v_reg <= accept && !drop;
            if (s2_adv)
                s2_v_reg <= s1_v_reg;
            if (s3_adv)
                s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_a_reg   <= magnitude(pixel.data.flux_down);
            s1_b_reg   <= magnitude(pixel.data.flux_right);
            s1_nd_reg  <= pixel.data.flux_down[ffed_pkg::FLUX_W-1];
            s1_nr_reg  <= pixel.data.flux_right[ffed_pkg::FLUX_W-1];
            s1_pos_reg <= pos_in;
        end
        if (s2_adv)
        begin
            s2_aa_reg  <= aa_full[ffed_pkg::SQ_W-1:0];
            s2_bb_reg  <= bb_full[ffed_pkg::SQ_W-1:0];
            s2_tt_reg  <= tt_full[ffed_pkg::SQ_W-1:0];
            s2_pa_reg  <= pa_full[ffed_pkg::SQ_W-1:0];
            s2_pb_reg  <= pb_full[ffed_pkg::SQ_W-1:0];
            s2_gta_reg <= gta;
            s2_gtb_reg <= gtb;
            s2_nd_reg  <= s1_nd_reg;
            s2_nr_reg  <= s1_nr_reg;
            s2_pos_reg <= s1_pos_reg;
        end
        if (s3_adv)
        begin
            s3_code_reg <= code_next;
            s3_pos_reg  <= s2_pos_reg;
        end
    end

    assign px_valid = s3_v_reg;
    assign px_code  = s3_code_reg;
    assign px_pos   = s3_pos_reg;

endmodule

`default_nettype wire

// ===== hdl/ffed_window.sv =====
// Line store, 3x3 window, ending test and output register.
`default_nettype none

module ffed_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        px_valid,
    output logic                        px_ready,
    input  logic [ffed_pkg::PIX_W-1:0]  px_code,
    input  ffed_pkg::pos_t              px_pos,
    ffed_out_if.source                  result
);

    logic                         s4_v_reg;
    logic                         s4_tail_reg;
    logic [ffed_pkg::PIX_W-1:0]   s4_code_reg;
    ffed_pkg::pos_t               s4_pos_reg;

    logic [2:0]                   top_reg;
    logic [ffed_pkg::PIX_W-1:0]   mid_reg [3];
    logic [2:0]                   bot_reg;

    logic [2:0]                   top_next;
    logic [ffed_pkg::PIX_W-1:0]   mid_next [3];
    logic [2:0]                   bot_next;
    logic [2:0]                   midm_next;

    logic                         res_v_reg;
    ffed_pkg::out_item_t          res_reg;
    ffed_pkg::out_item_t          res_next;

    logic [ffed_pkg::LINE_W-1:0]  line_rdata;
    logic                         line_we;
    logic                         take;
    logic                         step_has_res;
    logic                         out_free;
    logic                         step_go;
    logic                         need_tail;
    logic                         leave;
    logic                         in_top;
    logic [ffed_pkg::PIX_W-1:0]   in_mid;
    logic                         in_bot;

    // line word: older-row mask, previous-row mask and sector
    ffed_ram #(
        .WIDTH (ffed_pkg::LINE_W),
        .DEPTH (ffed_pkg::MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (s4_pos_reg.col),
        .wdata ({line_rdata[ffed_pkg::PIX_W-1], s4_code_reg}),
        .re    (take),
        .raddr (px_pos.col),
        .rdata (line_rdata)
    );

    assign take         = px_valid && px_ready;
    assign step_has_res = s4_tail_reg || (s4_pos_reg.row_ge1 && (s4_pos_reg.col != '0));
    assign out_free     = !res_v_reg || result.ready;
    assign step_go      = s4_v_reg && (!step_has_res || out_free);
    assign need_tail    = !s4_tail_reg && s4_pos_reg.last && s4_pos_reg.row_ge1;
    assign leave        = step_go && !need_tail;
    assign px_ready     = !s4_v_reg || leave;
    assign line_we      = step_go && !s4_tail_reg;

    // tail step shifts in an empty column past the row end
    always_comb
    begin
        if (s4_tail_reg)
        begin
            in_top = 1'b0;
            in_mid = '0;
            in_bot = 1'b0;
        end
        else
        begin
            in_top = line_rdata[ffed_pkg::PIX_W];
            in_mid = line_rdata[ffed_pkg::PIX_W-1:0];
            in_bot = s4_code_reg[ffed_pkg::SEC_W];
        end
    end

    assign top_next    = {in_top, top_reg[2:1]};
    assign bot_next    = {in_bot, bot_reg[2:1]};
    assign mid_next[0] = mid_reg[1];
    assign mid_next[1] = mid_reg[2];
    assign mid_next[2] = in_mid;
    assign midm_next   = {mid_next[2][ffed_pkg::SEC_W], mid_next[1][ffed_pkg::SEC_W],
                          mid_next[0][ffed_pkg::SEC_W]};

    always_comb
    begin
        res_next.is_ending  = ffed_pkg::is_end(mid_next[1], top_next, midm_next, bot_next,
                                               s4_pos_reg.row_ge2, !s4_pos_reg.flush,
                                               s4_tail_reg || (s4_pos_reg.col > 11'd1),
                                               !s4_tail_reg);
        res_next.pixel_column = s4_tail_reg ? s4_pos_reg.col : s4_pos_reg.col - 1'b1;
        res_next.row_done     = s4_tail_reg;
        res_next.frame_done   = s4_tail_reg && s4_pos_reg.flush;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg    <= 1'b0;
            s4_tail_reg <= 1'b0;
            res_v_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s4_v_reg    <= 1'b1;
                s4_tail_reg <= 1'b0;
            end
            else if (leave)
            begin
                s4_v_reg    <= 1'b0;
                s4_tail_reg <= 1'b0;
            end
            else if (step_go)
                s4_tail_reg <= 1'b1;

            if (step_go && step_has_res)
                res_v_reg <= 1'b1;
            else if (result.ready)
                res_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s4_code_reg <= px_code;
            s4_pos_reg  <= px_pos;
        end
        if (step_go)
        begin
            top_reg    <= top_next;
            mid_reg[0] <= mid_next[0];
            mid_reg[1] <= mid_next[1];
            mid_reg[2] <= mid_next[2];
            bot_reg    <= bot_next;
        end
        if (step_go && step_has_res)
            res_reg <= res_next;
    end

    assign result.valid = res_v_reg;
    assign result.data  = res_reg;

endmodule

`default_nettype wire

// ===== hdl/ffed_checker.sv =====
// Port-level assertions on the result channel, bound to the top level.
`default_nettype none

module ffed_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input ffed_pkg::out_item_t res_data
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_data))
        else $error("result payload changed while stalled");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.frame_done |-> res_data.row_done && (res_data.pixel_column != '0))
        else $error("frame end not on the last column of a row");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind flux_field_endpoint_detector ffed_checker u_ffed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);

`default_nettype wire
